>>> rtl/gnms_pkg.sv
// Shared types, constants and the angle-to-sector function for gradient NMS.
package gnms_pkg;

    // Field widths fixed by the pixel format.
    localparam int MAG_W   = 8;
    localparam int ANG_W   = 13;
    localparam int CFG_W   = 12;
    localparam int ROWS    = 5;

    // Line width limits and the width in use after reset.
    localparam int MIN_WIDTH   = 5;
    localparam int RESET_WIDTH = 1080;

    // Angle thresholds in 1/16 degree.
    localparam logic [ANG_W-1:0] HALF_TURN    = 13'd2880;
    localparam logic [ANG_W-1:0] FULL_TURN    = 13'd5760;
    localparam logic [ANG_W-1:0] SEC_LOW      = 13'd360;
    localparam logic [ANG_W-1:0] SEC_DIAG_END = 13'd1080;
    localparam logic [ANG_W-1:0] SEC_VERT_END = 13'd1800;
    localparam logic [ANG_W-1:0] SEC_HIGH     = 13'd2520;

    typedef enum logic [1:0] {
        SEC_HORZ = 2'd0,
        SEC_DIAG = 2'd1,
        SEC_VERT = 2'd2,
        SEC_ANTI = 2'd3
    } t_sector;

    // One window column, index 0 is the oldest row.
    typedef logic [ROWS-1:0][MAG_W-1:0] t_column;

    // Control that travels with a pixel through the pipeline.
    typedef struct packed {
        logic valid;
        logic emit;
        logic interior;
    } t_stage;

    // Result leaving the compare stage.
    typedef struct packed {
        logic valid;
        logic emit;
        logic res;
    } t_result;

    // Reduce the angle modulo a half turn and sort it into a sector.
    function automatic t_sector sector_of(input logic [ANG_W-1:0] angle);
        logic [ANG_W-1:0] d;
        t_sector          s;
        if (angle >= FULL_TURN) begin
            d = angle - FULL_TURN;
        end else if (angle >= HALF_TURN) begin
            d = angle - HALF_TURN;
        end else begin
            d = angle;
        end
        if (d < SEC_LOW || d >= SEC_HIGH) begin
            s = SEC_HORZ;
        end else if (d < SEC_DIAG_END) begin
            s = SEC_DIAG;
        end else if (d < SEC_VERT_END) begin
            s = SEC_VERT;
        end else begin
            s = SEC_ANTI;
        end
        return s;
    endfunction

endpackage

>>> rtl/gnms_line_store.sv
// Simple dual-port line store with a registered read, read-before-write.
module gnms_line_store #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same entry is written.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/gnms_window.sv
// 5x5 magnitude window, centre sector delay and the suppression compare.
module gnms_window (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gnms_pkg::t_stage        i_stage,
    input  gnms_pkg::t_column       i_column,
    input  gnms_pkg::t_sector       i_old_sec,
    output gnms_pkg::t_result       o_result
);

    logic [gnms_pkg::ROWS-1:0][gnms_pkg::ROWS-1:0][gnms_pkg::MAG_W-1:0] r_win;
    gnms_pkg::t_sector r_sp0;
    gnms_pkg::t_sector r_sp1;
    gnms_pkg::t_sector r_csec;
    gnms_pkg::t_stage  r_s2;

    logic [gnms_pkg::MAG_W-1:0] ctr;
    logic [gnms_pkg::MAG_W-1:0] n1;
    logic [gnms_pkg::MAG_W-1:0] n2;
    logic [gnms_pkg::MAG_W-1:0] n3;
    logic [gnms_pkg::MAG_W-1:0] n4;

    // Control of the compare stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= i_stage;
        end
    end

    // Shift the window left by one column and step the sector delay.
    always_ff @(posedge i_clk) begin
        if (i_stage.valid) begin
            for (int r = 0; r < gnms_pkg::ROWS; r++) begin
                for (int k = 0; k < gnms_pkg::ROWS - 1; k++) begin
                    r_win[r][k] <= r_win[r][k+1];
                end
                r_win[r][gnms_pkg::ROWS-1] <= i_column[r];
            end
            r_csec <= r_sp1;
            r_sp1  <= r_sp0;
            r_sp0  <= i_old_sec;
        end
    end

    // Pick the four neighbors along the centre pixel's sector.
    always_comb begin
        ctr = r_win[2][2];
        case (r_csec)
            gnms_pkg::SEC_HORZ: begin
                n1 = r_win[2][1];
                n2 = r_win[2][0];
                n3 = r_win[2][3];
                n4 = r_win[2][4];
            end
            gnms_pkg::SEC_DIAG: begin
                n1 = r_win[1][1];
                n2 = r_win[0][0];
                n3 = r_win[3][3];
                n4 = r_win[4][4];
            end
            gnms_pkg::SEC_VERT: begin
                n1 = r_win[1][2];
                n2 = r_win[0][2];
                n3 = r_win[3][2];
                n4 = r_win[4][2];
            end
            gnms_pkg::SEC_ANTI: begin
                n1 = r_win[1][3];
                n2 = r_win[0][4];
                n3 = r_win[3][1];
                n4 = r_win[4][0];
            end
            default: begin
                n1 = r_win[2][1];
                n2 = r_win[2][0];
                n3 = r_win[2][3];
                n4 = r_win[2][4];
            end
        endcase
    end

    // The centre survives when it ties or beats the first negative neighbor
    // and strictly beats the other three; border pixels always give zero.
    always_comb begin
        o_result.valid = r_s2.valid;
        o_result.emit  = r_s2.emit;
        o_result.res   = r_s2.interior && (ctr >= n1) && (ctr > n2)
                         && (ctr > n3) && (ctr > n4);
    end

endmodule

>>> rtl/gnms_out_fifo.sv
// Four-entry result queue that decouples the pipeline from the output stall.
module gnms_out_fifo (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_data,
    input  logic       i_stall,
    output logic       o_valid,
    output logic       o_data,
    output logic [2:0] o_count
);

    localparam int DEPTH = 4;

    logic [DEPTH-1:0] r_data;
    logic [1:0]       r_wptr;
    logic [1:0]       r_rptr;
    logic [2:0]       r_count;
    logic             pop;

    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_data[r_rptr];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 2'd1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 2'd1;
            end
            r_count <= r_count + 3'(i_push) - 3'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

>>> rtl/gradient_nonmax_suppression.sv
// Top level of the 5x5 gradient non-maximum suppression block.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_magnitude, i_angle, i_frame_start
//   output    out        o_out_valid / i_out_stall o_edge_res
//   config    in         i_cfg_we                  i_cfg_wdata (image width)
//
// One pixel is taken per cycle while the input is not stalled; its result, if any,
// passes stage 1 and the compare stage into the result queue, which offers it.
// The line stores are read at accept and written back in the following cycle, with a
// forward path for back-to-back beats at the same column.
// Reset is synchronous; no store clearing pass is run, so a pixel may enter as soon as
// reset is released. The input stalls when the beats held in the
// 4-entry result queue and the two pipeline stages together reach four.
module gradient_nonmax_suppression #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gnms_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [gnms_pkg::MAG_W-1:0]  i_magnitude,
    input  logic [gnms_pkg::ANG_W-1:0]  i_angle,
    input  logic                        i_frame_start,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_edge_res
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int MAG_W   = gnms_pkg::MAG_W;
    localparam int MWORD_W = 4 * MAG_W;
    localparam int SWORD_W = 4;
    localparam int RESET_LAST = (gnms_pkg::RESET_WIDTH > MAX_WIDTH) ? (MAX_WIDTH - 1)
                                                                    : (gnms_pkg::RESET_WIDTH - 1);

    // Configuration and position state.
    logic [CW-1:0] r_wlast;
    logic [CW-1:0] n_wlast;
    logic [CW-1:0] r_col;
    logic [1:0]    r_row;
    logic          r_primed;

    // Stage 1 registers.
    gnms_pkg::t_stage  r_s1;
    logic [CW-1:0]     r_s1_addr;
    logic [MAG_W-1:0]  r_s1_mag;
    gnms_pkg::t_sector r_s1_sec;
    logic              r_fwd;
    logic [MWORD_W-1:0] r_last_mword;
    logic [SWORD_W-1:0] r_last_sword;

    logic               accept;
    logic [CW-1:0]      c0;
    logic [1:0]         row0;
    logic               pr0;
    logic               prime_now;
    logic [1:0]         row1;
    gnms_pkg::t_stage   s0;
    logic [MWORD_W-1:0] mag_rdata;
    logic [SWORD_W-1:0] sec_rdata;
    logic [MWORD_W-1:0] mword;
    logic [SWORD_W-1:0] sword;
    logic [MWORD_W-1:0] n_mword;
    logic [SWORD_W-1:0] n_sword;
    gnms_pkg::t_column  column;
    gnms_pkg::t_result  result;
    logic [2:0]         fifo_count;
    logic [2:0]         in_flight;

    // Flow control: never hold more beats than the result queue can absorb.
    assign in_flight  = fifo_count + 3'(r_s1.valid) + 3'(result.valid);
    assign o_in_stall = !i_rst_n || (in_flight >= 3'd4);
    assign accept     = i_in_valid && !o_in_stall;

    // Effective width minus one, clamped to the supported range.
    always_comb begin
        logic [31:0] w_ext;
        w_ext = 32'(i_cfg_wdata);
        if (w_ext < 32'(gnms_pkg::MIN_WIDTH)) begin
            n_wlast = CW'(gnms_pkg::MIN_WIDTH - 1);
        end else if (w_ext > 32'(MAX_WIDTH)) begin
            n_wlast = CW'(MAX_WIDTH - 1);
        end else begin
            n_wlast = CW'(w_ext - 32'd1);
        end
    end

    // Stage 0: position of the arriving pixel and its warm-up and border flags.
    always_comb begin
        c0        = i_frame_start ? '0 : r_col;
        row0      = i_frame_start ? 2'd0 : r_row;
        pr0       = i_frame_start ? 1'b0 : r_primed;
        prime_now = !pr0 && (row0 == 2'd2) && (c0 == CW'(2));
        row1      = prime_now ? 2'd0 : row0;
        s0.valid    = accept;
        s0.emit     = pr0 || prime_now;
        s0.interior = (row1 >= 2'd2) && (c0 >= CW'(4));
    end

    // Width register and raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast  <= CW'(RESET_LAST);
            r_col    <= '0;
            r_row    <= '0;
            r_primed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wlast <= n_wlast;
            end
            if (accept) begin
                r_primed <= pr0 || prime_now;
                if (c0 >= r_wlast) begin
                    r_col <= '0;
                    r_row <= (row1 < 2'd3) ? row1 + 2'd1 : row1;
                end else begin
                    r_col <= c0 + CW'(1);
                    r_row <= row1;
                end
            end
        end
    end

    // Stage 1 control and the forward flag for a same-column follow-up beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_fwd <= 1'b0;
        end else begin
            r_s1  <= s0;
            r_fwd <= accept && r_s1.valid && (c0 == r_s1_addr);
        end
    end

    // Stage 1 payload and the last written words.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr <= c0;
            r_s1_mag  <= i_magnitude;
            r_s1_sec  <= gnms_pkg::sector_of(i_angle);
        end
        if (r_s1.valid) begin
            r_last_mword <= n_mword;
            r_last_sword <= n_sword;
        end
    end

    // Stage 1: shift the stored column up by one row and insert the new pixel.
    always_comb begin
        mword   = r_fwd ? r_last_mword : mag_rdata;
        sword   = r_fwd ? r_last_sword : sec_rdata;
        n_mword = {mword[3*MAG_W-1:0], r_s1_mag};
        n_sword = {sword[1:0], r_s1_sec};
        column[0] = mword[4*MAG_W-1:3*MAG_W];
        column[1] = mword[3*MAG_W-1:2*MAG_W];
        column[2] = mword[2*MAG_W-1:MAG_W];
        column[3] = mword[MAG_W-1:0];
        column[4] = r_s1_mag;
    end

    gnms_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (MWORD_W)
    ) u_mag_store (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (c0),
        .o_rdata (mag_rdata),
        .i_we    (r_s1.valid),
        .i_waddr (r_s1_addr),
        .i_wdata (n_mword)
    );

    gnms_line_store #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (SWORD_W)
    ) u_sec_store (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (c0),
        .o_rdata (sec_rdata),
        .i_we    (r_s1.valid),
        .i_waddr (r_s1_addr),
        .i_wdata (n_sword)
    );

    gnms_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (r_s1),
        .i_column  (column),
        .i_old_sec (gnms_pkg::t_sector'(sword[3:2])),
        .o_result  (result)
    );

    gnms_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result.valid && result.emit),
        .i_data  (result.res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_edge_res),
        .o_count (fifo_count)
    );

endmodule

>>> rtl/gnms_checker.sv
// Port-level checks for the gradient NMS block, bound to its top level.
module gnms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [11:0] i_cfg_wdata,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_magnitude,
    input logic [12:0] i_angle,
    input logic        i_frame_start,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_edge_res
);

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_edge_res))
        else $error("stalled result changed");

    // A result can only appear when it traces back to an accepted input beat.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 3))
        else $error("result without a matching input beat");

    // The input stall clears in the cycle after the output drains a beat.
    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !i_out_stall |=> !o_in_stall)
        else $error("input stall held while the output drains");

endmodule

bind gradient_nonmax_suppression gnms_checker u_gnms_checker (.*);
